[hdl/merco_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merco_pkg
// Shared types and constants of the matrix row and column operations unit.
// ----------------------------------------------------------------------------
package merco_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_ROWSWAP = 3'd2,
    OP_COLSWAP = 3'd3,
    OP_ROWADD  = 3'd4,
    OP_COLADD  = 3'd5,
    OP_ROWMUL  = 3'd6,
    OP_COLMUL  = 3'd7
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         index_a;
    logic [3:0]         index_b;
    logic signed [31:0] factor;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               status;
  } rsp_t;

endpackage

[hdl/merco_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merco_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module merco_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/merco_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merco_mod
// Remainder of the magnitude of a signed word by a 16-bit modulus, four
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module merco_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  input  logic [15:0] modulus_i,
  output logic        done_o,
  output logic [15:0] rem_o
);

  logic        busy_q, done_q;
  logic [2:0]  cnt_q;
  logic [31:0] num_q;
  logic [15:0] rem_q, rem_d;

  always_comb begin
    logic [16:0] t;
    logic [15:0] r;
    r = rem_q;
    for (int i = 0; i < 4; i++) begin
      t = {r, num_q[31-i]};
      if (t >= {1'b0, modulus_i}) begin
        t = t - {1'b0, modulus_i};
      end
      r = t[15:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= value_i[31] ? (~value_i + 32'd1) : value_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[27:0], 4'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[hdl/matrix_elementary_row_col_ops_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_elementary_row_col_ops_unit
// Integer matrix held in one RAM with element access, row and column swaps,
// scaled row and column adds and row and column scaling.
//
//   channel   handshake                 word
//   request   start_i, busy_o           req_i (merco_pkg::req_t)
//   result    done_o strobe, one cycle  rsp_o (merco_pkg::rsp_t)
//   config    cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// A write and a failed request finish from S_IDLE; a read passes S_RDOUT.
// Per entry of the line a swap reads both entries and writes both back; an
// add or multiply reads both, multiplies, adds, takes the remainder when the
// modulus is nonzero and writes one entry. After reset a clearing pass over
// every RAM word holds busy_o high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module matrix_elementary_row_col_ops_unit #(
  parameter int MAX_DIM = merco_pkg::MAX_DIM_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  merco_pkg::req_t                     req_i,
  output logic                                busy_o,
  output logic                                done_o,
  output merco_pkg::rsp_t                     rsp_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [merco_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [merco_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int LW    = (CW > 5) ? CW : 5;
  localparam int AW    = 2 * DIM_W;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDOUT, S_RD1, S_RD2, S_CAP, S_MUL, S_ADD,
    S_MODGO, S_MOD, S_WR1, S_WR2
  } state_e;

  state_e               state_q;
  merco_pkg::op_e       op_q, op_in;
  logic [3:0]           a_q, b_q;
  logic [31:0]          fac_q, v1_q, v2_q, res_q;
  logic [LW-1:0]        len_q, k_q, rows_lim, cols_lim, ia, ib, len_in;
  logic [AW-1:0]        clr_q, addr1, addr2, addr_in;
  logic                 done_q, bad;
  merco_pkg::rsp_t      rsp_q;
  logic [15:0]          modulus_q;
  logic [4:0]           row_count_q, col_count_q;
  logic                 is_swap, is_add, is_col, last;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [31:0]          wdata, rdata;
  logic                 mod_start, mod_done;
  logic [15:0]          mod_rem;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= '0;
      row_count_q <= 5'd16;
      col_count_q <= 5'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        merco_pkg::CFG_MODULUS:   modulus_q   <= cfg_data_i[15:0];
        merco_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data_i[4:0];
        merco_pkg::CFG_COL_COUNT: col_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign rows_lim = (LW'(row_count_q) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(row_count_q);
  assign cols_lim = (LW'(col_count_q) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(col_count_q);
  assign op_in    = merco_pkg::op_e'(req_i.req_type);
  assign ia       = LW'(req_i.index_a);
  assign ib       = LW'(req_i.index_b);
  assign addr_in  = {DIM_W'(req_i.index_a), DIM_W'(req_i.index_b)};
  assign len_in   = req_i.req_type[0] ? rows_lim : cols_lim;

  always_comb begin
    unique case (op_in) inside
      merco_pkg::OP_WRITE, merco_pkg::OP_READ:    bad = (ia >= rows_lim) || (ib >= cols_lim);
      merco_pkg::OP_ROWSWAP, merco_pkg::OP_ROWADD: bad = (ia >= rows_lim) || (ib >= rows_lim);
      merco_pkg::OP_COLSWAP, merco_pkg::OP_COLADD: bad = (ia >= cols_lim) || (ib >= cols_lim);
      merco_pkg::OP_ROWMUL:                        bad = (ia >= rows_lim);
      default:                                     bad = (ia >= cols_lim);
    endcase
  end

  assign is_swap = (op_q == merco_pkg::OP_ROWSWAP) || (op_q == merco_pkg::OP_COLSWAP);
  assign is_add  = (op_q == merco_pkg::OP_ROWADD) || (op_q == merco_pkg::OP_COLADD);
  assign is_col  = op_q[0];
  assign addr1   = is_col ? {k_q[DIM_W-1:0], DIM_W'(a_q)} : {DIM_W'(a_q), k_q[DIM_W-1:0]};
  assign addr2   = is_col ? {k_q[DIM_W-1:0], DIM_W'(b_q)} : {DIM_W'(b_q), k_q[DIM_W-1:0]};
  assign last    = (k_q + LW'(1)) == len_q;

  always_comb begin
    we    = 1'b0;
    waddr = addr1;
    wdata = res_q;
    raddr = addr1;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
      end
      S_IDLE: begin
        raddr = addr_in;
        waddr = addr_in;
        wdata = req_i.write_value;
        we    = start_i && !bad && (op_in == merco_pkg::OP_WRITE);
      end
      S_RD2: raddr = addr2;
      S_WR1: begin
        we = 1'b1;
        if (is_swap) begin
          wdata = v2_q;
        end else if (is_add) begin
          waddr = addr2;
        end
      end
      S_WR2: begin
        we    = 1'b1;
        waddr = addr2;
        wdata = v1_q;
      end
      default: ;
    endcase
  end

  assign mod_start = (state_q == S_MODGO);

  merco_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  merco_mod u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mod_start),
    .value_i  (res_q),
    .modulus_i(modulus_q),
    .done_o   (mod_done),
    .rem_o    (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
      op_q    <= merco_pkg::OP_WRITE;
      a_q     <= '0;
      b_q     <= '0;
      fac_q   <= '0;
      len_q   <= '0;
      k_q     <= '0;
      v1_q    <= '0;
      v2_q    <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            op_q                <= op_in;
            a_q                 <= req_i.index_a;
            b_q                 <= req_i.index_b;
            fac_q               <= req_i.factor;
            len_q               <= len_in;
            k_q                 <= '0;
            rsp_q.read_value    <= '0;
            rsp_q.status        <= bad;
            if (bad || op_in == merco_pkg::OP_WRITE || len_in == '0) begin
              done_q <= 1'b1;
            end else if (op_in == merco_pkg::OP_READ) begin
              state_q <= S_RDOUT;
            end else begin
              state_q <= S_RD1;
            end
          end
        end
        S_RDOUT: begin
          rsp_q.read_value <= rdata;
          done_q           <= 1'b1;
          state_q          <= S_IDLE;
        end
        S_RD1: state_q <= S_RD2;
        S_RD2: begin
          v1_q    <= rdata;
          state_q <= S_CAP;
        end
        S_CAP: begin
          v2_q    <= rdata;
          state_q <= is_swap ? S_WR1 : S_MUL;
        end
        S_MUL: begin
          res_q   <= v1_q * fac_q;
          state_q <= S_ADD;
        end
        S_ADD: begin
          res_q   <= res_q + (is_add ? v2_q : 32'd0);
          state_q <= (modulus_q != '0) ? S_MODGO : S_WR1;
        end
        S_MODGO: state_q <= S_MOD;
        S_MOD: begin
          if (mod_done) begin
            res_q   <= {16'd0, mod_rem};
            state_q <= S_WR1;
          end
        end
        S_WR1: begin
          if (is_swap) begin
            state_q <= S_WR2;
          end else if (last) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            k_q     <= k_q + LW'(1);
            state_q <= S_RD1;
          end
        end
        S_WR2: begin
          if (last) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            k_q     <= k_q + LW'(1);
            state_q <= S_RD1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
